// File: hdl/cre_pkg.sv
// shared constants, types and coefficient table for the curve evaluator
`timescale 1ns / 1ps
`default_nettype none
package cre_pkg;

    localparam int MAX_KEYS = 16;
    localparam int AW       = $clog2(MAX_KEYS);
    localparam int CW       = $clog2(MAX_KEYS + 1);
    localparam int KC_W     = 5;
    localparam int DIV_STEPS = 16;

    // result source codes
    localparam logic [2:0] RS_ZERO   = 3'd0;
    localparam logic [2:0] RS_FEW    = 3'd1;
    localparam logic [2:0] RS_LOW    = 3'd2;
    localparam logic [2:0] RS_HIGH   = 3'd3;
    localparam logic [2:0] RS_INTERP = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FEW   = 2'd1;
    localparam logic [1:0] ST_CLAMP = 2'd2;

    // catmull-rom basis coefficients, row per neighbor key, cubic term first
    localparam logic signed [3:0] BASIS_COEF [16] = '{
        -4'sd1,  4'sd2, -4'sd1,  4'sd0,
         4'sd3, -4'sd5,  4'sd0,  4'sd2,
        -4'sd3,  4'sd4,  4'sd1,  4'sd0,
         4'sd1, -4'sd1,  4'sd0,  4'sd0
    };

    typedef struct packed {
        logic          wr_en;
        logic          load_t;
        logic          rd_en;
        logic [AW-1:0] rd_addr;
        logic          cap_key;
        logic          div_init;
        logic          div_step;
        logic          h2_en;
        logic          h3_en;
        logic          w_en;
        logic [1:0]    w_row;
        logic          mac_clr;
        logic          mac_en;
        logic          res_load;
        logic [2:0]    res_sel;
    } t_cmd;

    typedef struct packed {
        logic x_ge_t;
        logic out_busy;
    } t_sts;

endpackage
`default_nettype wire

// File: hdl/cre_in_if.sv
// input item channel
`timescale 1ns / 1ps
`default_nettype none
interface cre_in_if;
    logic               valid;
    logic               ready;
    logic               action;
    logic [3:0]         key_index;
    logic [15:0]        key_x;
    logic signed [15:0] key_y;
    logic [15:0]        position;

    modport source (output valid, action, key_index, key_x, key_y, position, input ready);
    modport sink   (input valid, action, key_index, key_x, key_y, position, output ready);
endinterface
`default_nettype wire

// File: hdl/cre_out_if.sv
// result item channel
`timescale 1ns / 1ps
`default_nettype none
interface cre_out_if;
    logic               valid;
    logic               ready;
    logic signed [17:0] curve_value;
    logic [1:0]         status;

    modport source (output valid, curve_value, status, input ready);
    modport sink   (input valid, curve_value, status, output ready);
endinterface
`default_nettype wire

// File: hdl/cre_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module cre_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

// File: hdl/cre_dp.sv
// datapath: key store, search compare, divider, basis weights and accumulator
`timescale 1ns / 1ps
`default_nettype none
module cre_dp
    import cre_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cmd               i_cmd,
    output t_sts                    o_sts,
    input  wire logic [3:0]         i_key_index,
    input  wire logic [15:0]        i_key_x,
    input  wire logic [15:0]        i_key_y,
    input  wire logic [15:0]        i_position,
    input  wire logic               i_out_ready,
    output logic                    o_out_valid,
    output logic signed [17:0]      o_curve_value,
    output logic [1:0]              o_status
);
    logic [31:0]        rdata;
    logic [15:0]        rd_x;
    logic signed [15:0] rd_y;
    logic               key_ok;

    logic [15:0]        r_t, r_xprev;
    logic signed [15:0] r_yprev;
    logic [15:0]        r_den, r_rem;
    logic [16:0]        r_h;
    logic [33:0]        r_h2;
    logic [48:0]        r_h3;
    logic signed [19:0] r_w;
    logic signed [37:0] r_acc;
    logic               r_valid;
    logic signed [17:0] r_curve;
    logic [1:0]         r_status;

    logic [15:0]        num, den;
    logic [16:0]        rem2;
    logic               rem_ge;
    logic signed [52:0] poly;
    logic signed [52:0] poly_r;
    logic signed [35:0] prod;
    logic signed [37:0] acc_r;
    logic signed [21:0] res;
    logic signed [17:0] res_sat;

    assign key_ok = 32'(i_key_index) < MAX_KEYS;

    cre_ram #(.WIDTH(32), .DEPTH(MAX_KEYS)) u_keys (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_en && key_ok),
        .i_waddr (AW'(i_key_index)),
        .i_wdata ({i_key_x, i_key_y}),
        .i_re    (i_cmd.rd_en),
        .i_raddr (i_cmd.rd_addr),
        .o_rdata (rdata)
    );

    assign rd_x = rdata[31:16];
    assign rd_y = $signed(rdata[15:0]);

    assign o_sts.x_ge_t   = rd_x >= r_t;
    assign o_sts.out_busy = r_valid && !i_out_ready;

    // divider operands and one restoring step
    assign num    = r_t - r_xprev;
    assign den    = rd_x - r_xprev;
    assign rem2   = {r_rem, 1'b0};
    assign rem_ge = rem2 >= {1'b0, r_den};

    // basis polynomial for the selected row, scaled by 2^48
    always_comb begin
        poly = 53'(BASIS_COEF[{i_cmd.w_row, 2'd0}]) * $signed({4'd0, r_h3})
             + 53'(BASIS_COEF[{i_cmd.w_row, 2'd1}]) * $signed({3'd0, r_h2, 16'd0})
             + 53'(BASIS_COEF[{i_cmd.w_row, 2'd2}]) * $signed({4'd0, r_h, 32'd0})
             + 53'(BASIS_COEF[{i_cmd.w_row, 2'd3}]) * $signed({5'd1, 48'd0});
        poly_r = (poly + $signed(53'd1 << 32)) >>> 33;
    end

    assign prod  = r_w * rd_y;
    assign acc_r = (r_acc + 38'sd32768) >>> 16;
    assign res   = acc_r[21:0];

    // saturate to 18 bits
    always_comb begin
        if (res > 22'sd131071) begin
            res_sat = 18'sd131071;
        end else if (res < -22'sd131072) begin
            res_sat = -18'sd131072;
        end else begin
            res_sat = res[17:0];
        end
    end

    // search, divide and multiply registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_t) begin
            r_t <= i_position;
        end
        if (i_cmd.cap_key) begin
            r_xprev <= rd_x;
            r_yprev <= rd_y;
        end
        if (i_cmd.div_init) begin
            r_den <= den;
            r_rem <= (num >= den) ? num - den : num;
            r_h   <= {16'd0, num >= den};
        end else if (i_cmd.div_step) begin
            r_rem <= rem_ge ? 16'(rem2 - {1'b0, r_den}) : rem2[15:0];
            r_h   <= {r_h[15:0], rem_ge};
        end
        if (i_cmd.h2_en) begin
            r_h2 <= r_h * r_h;
        end
        if (i_cmd.h3_en) begin
            r_h3 <= 49'(r_h2 * r_h);
        end
        if (i_cmd.w_en) begin
            r_w <= poly_r[19:0];
        end
        if (i_cmd.mac_clr) begin
            r_acc <= '0;
        end else if (i_cmd.mac_en) begin
            r_acc <= r_acc + 38'(prod);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.res_load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            case (i_cmd.res_sel)
                RS_ZERO: begin
                    r_curve  <= '0;
                    r_status <= ST_OK;
                end
                RS_FEW: begin
                    r_curve  <= '0;
                    r_status <= ST_FEW;
                end
                RS_LOW: begin
                    r_curve  <= 18'(r_yprev);
                    r_status <= (r_xprev != r_t) ? ST_CLAMP : ST_OK;
                end
                RS_HIGH: begin
                    r_curve  <= 18'(r_yprev);
                    r_status <= ST_CLAMP;
                end
                RS_INTERP: begin
                    r_curve  <= res_sat;
                    r_status <= ST_OK;
                end
                default: begin
                    r_curve  <= '0;
                    r_status <= ST_OK;
                end
            endcase
        end
    end

    assign o_out_valid   = r_valid;
    assign o_curve_value = r_curve;
    assign o_status      = r_status;
endmodule
`default_nettype wire

// File: hdl/cre_ctrl.sv
// controller: key count register and evaluation sequencer
`timescale 1ns / 1ps
`default_nettype none
module cre_ctrl
    import cre_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cfg_we,
    input  wire logic [KC_W-1:0] i_cfg_wdata,
    input  wire logic            i_in_valid,
    input  wire logic            i_in_action,
    output logic                 o_in_ready,
    output t_cmd                 o_cmd,
    input  wire t_sts            i_sts
);
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD   = 4'd1;
    localparam logic [3:0] S_CMP  = 4'd2;
    localparam logic [3:0] S_DIV  = 4'd3;
    localparam logic [3:0] S_H2   = 4'd4;
    localparam logic [3:0] S_H3   = 4'd5;
    localparam logic [3:0] S_WRD  = 4'd6;
    localparam logic [3:0] S_WMAC = 4'd7;
    localparam logic [3:0] S_DONE = 4'd8;

    logic [3:0]      r_state, n_state;
    logic [KC_W-1:0] r_key_count;
    logic [CW-1:0]   r_k, n_k;
    logic [1:0]      r_i, n_i;
    logic [3:0]      r_cnt, n_cnt;
    logic [2:0]      r_sel, n_sel;

    logic [CW-1:0]         n_keys;
    logic signed [CW+1:0]  kn;
    logic signed [CW+1:0]  klast;
    logic [AW-1:0]         kn_addr;
    logic                  accept;

    // effective key count
    assign n_keys = (32'(r_key_count) < MAX_KEYS) ? CW'(r_key_count) : CW'(MAX_KEYS);

    // neighbor index clamped to the table
    always_comb begin
        kn    = $signed({2'b00, r_k}) + $signed({{CW{1'b0}}, r_i}) - $signed((CW+2)'(2));
        klast = $signed({2'b00, n_keys}) - $signed((CW+2)'(1));
        if (kn < 0) begin
            kn_addr = '0;
        end else if (kn > klast) begin
            kn_addr = klast[AW-1:0];
        end else begin
            kn_addr = kn[AW-1:0];
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_i     = r_i;
        n_cnt   = r_cnt;
        n_sel   = r_sel;
        o_cmd   = '0;
        o_cmd.res_sel = r_sel;
        o_cmd.w_row   = r_i;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (!i_in_action) begin
                        o_cmd.wr_en = 1'b1;
                        n_sel   = RS_ZERO;
                        n_state = S_DONE;
                    end else if (n_keys < CW'(2)) begin
                        n_sel   = RS_FEW;
                        n_state = S_DONE;
                    end else begin
                        o_cmd.load_t = 1'b1;
                        n_k     = '0;
                        n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_addr = r_k[AW-1:0];
                n_state = S_CMP;
            end
            S_CMP: begin
                if (i_sts.x_ge_t) begin
                    if (r_k == '0) begin
                        o_cmd.cap_key = 1'b1;
                        n_sel   = RS_LOW;
                        n_state = S_DONE;
                    end else begin
                        o_cmd.div_init = 1'b1;
                        o_cmd.mac_clr  = 1'b1;
                        n_cnt   = '0;
                        n_state = S_DIV;
                    end
                end else begin
                    o_cmd.cap_key = 1'b1;
                    if (r_k == n_keys - CW'(1)) begin
                        n_sel   = RS_HIGH;
                        n_state = S_DONE;
                    end else begin
                        n_k     = r_k + CW'(1);
                        n_state = S_RD;
                    end
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == 4'(DIV_STEPS - 1)) begin
                    n_state = S_H2;
                end
            end
            S_H2: begin
                o_cmd.h2_en = 1'b1;
                n_state = S_H3;
            end
            S_H3: begin
                o_cmd.h3_en = 1'b1;
                n_i     = '0;
                n_state = S_WRD;
            end
            S_WRD: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_addr = kn_addr;
                o_cmd.w_en    = 1'b1;
                n_state = S_WMAC;
            end
            S_WMAC: begin
                o_cmd.mac_en = 1'b1;
                if (r_i == 2'd3) begin
                    n_sel   = RS_INTERP;
                    n_state = S_DONE;
                end else begin
                    n_i     = r_i + 2'd1;
                    n_state = S_WRD;
                end
            end
            S_DONE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.res_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_key_count <= '0;
            r_k         <= '0;
            r_i         <= '0;
            r_cnt       <= '0;
            r_sel       <= RS_ZERO;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_i     <= n_i;
            r_cnt   <= n_cnt;
            r_sel   <= n_sel;
            if (i_cfg_we) begin
                r_key_count <= i_cfg_wdata;
            end
        end
    end

`ifndef SYNTH
    // search index stays inside the keys in use
    a_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> (r_k < n_keys))
        else $error("search index beyond key count");

    // a key write goes straight to the result state
    a_write_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !i_in_action) |=> (r_state == S_DONE))
        else $error("key write did not go to result");

    // a result is loaded only into a free output register
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.res_load |-> !i_sts.out_busy)
        else $error("result loaded over a pending item");

    // divider leaves after its last step
    a_div_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_cnt == 4'(DIV_STEPS - 1)) |=> (r_state == S_H2))
        else $error("divider step count wrong");
`endif
endmodule
`default_nettype wire

// File: hdl/catmull_rom_curve_eval_unit.sv
// top level of the catmull-rom curve evaluator
// a key write or a too-few-keys evaluation goes from accept straight to the result state
// evaluation: a read and a compare per key searched (up to 16 keys), then 16 divider steps, the
// h squared and h cubed products, then a read and multiply-accumulate for each of four basis terms
// one item at a time; the next item is accepted while the last result waits
// reset (synchronous, active low) clears key_count to 0; key slots are undefined until written
`timescale 1ns / 1ps
`default_nettype none
module catmull_rom_curve_eval_unit
    import cre_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cfg_we,
    input  wire logic [KC_W-1:0] i_cfg_wdata,
    cre_in_if.sink               i_item,
    cre_out_if.source            o_result
);
    t_cmd cmd;
    t_sts sts;

    // sequencer
    cre_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_item.valid),
        .i_in_action (i_item.action),
        .o_in_ready  (i_item.ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    // arithmetic and key store
    cre_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_key_index   (i_item.key_index),
        .i_key_x       (i_item.key_x),
        .i_key_y       (i_item.key_y),
        .i_position    (i_item.position),
        .i_out_ready   (o_result.ready),
        .o_out_valid   (o_result.valid),
        .o_curve_value (o_result.curve_value),
        .o_status      (o_result.status)
    );
endmodule
`default_nettype wire

// File: sim/catmull_rom_curve_eval_unit_test.sv
// self-checking testbench for the catmull-rom curve evaluator
`timescale 1ns / 1ps
module catmull_rom_curve_eval_unit_test;
    import cre_pkg::*;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_EVAL  = 1'b1;
    localparam int   CYCLE_LIMIT = 1_000_000;
    localparam int   LONG_HOLD   = 300;
    localparam int   ROW_COEF [16] = '{-1, 2, -1, 0, 3, -5, 0, 2, -3, 4, 1, 0, 1, -1, 0, 0};

    typedef struct {
        logic               action;
        logic [3:0]         key_index;
        logic [15:0]        key_x;
        logic signed [15:0] key_y;
        logic [15:0]        position;
    } curve_item_t;

    typedef struct {
        logic signed [17:0] curve_value;
        logic [1:0]         status;
    } curve_result_t;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [KC_W-1:0] i_cfg_wdata;

    cre_in_if  in_if ();
    cre_out_if out_if ();

    catmull_rom_curve_eval_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_item      (in_if),
        .o_result    (out_if)
    );

    // predictor state: key table and key_count as the block should hold them
    logic [15:0]        model_kx [16];
    logic signed [15:0] model_ky [16];
    int unsigned        model_key_count;

    curve_item_t   pending_items [$];
    curve_result_t awaited_results [$];

    int  send_idle_pct;
    int  recv_stall_pct;
    int  fail_count;
    int  items_sent;
    int  results_checked;
    int  evals_sent;
    int  cycle_count;
    bit  hold_request;
    bit  hold_seen;
    int  hold_left;

    // clock
    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // expected result of an evaluation at position t
    function automatic curve_result_t predict_curve(logic [15:0] t);
        curve_result_t r;
        int unsigned n;
        int unsigned k;
        longint num;
        longint den;
        longint h;
        longint h2;
        longint h3;
        longint poly;
        longint w;
        longint sum;
        longint res;
        int kn;
        n = (model_key_count > 16) ? 16 : model_key_count;
        r.curve_value = '0;
        r.status = ST_OK;
        if (n < 2) begin
            r.status = ST_FEW;
            return r;
        end
        k = 0;
        while (k < n && model_kx[k] < t) k++;
        if (k == n) begin
            r.curve_value = 18'(model_ky[n-1]);
            r.status = ST_CLAMP;
            return r;
        end
        if (k == 0) begin
            r.curve_value = 18'(model_ky[0]);
            r.status = (t < model_kx[0]) ? ST_CLAMP : ST_OK;
            return r;
        end
        num = longint'(t) - longint'(model_kx[k-1]);
        den = longint'(model_kx[k]) - longint'(model_kx[k-1]);
        h = (num <<< 16) / den;
        h2 = h * h;
        h3 = h2 * h;
        sum = 0;
        for (int i = 0; i < 4; i++) begin
            kn = int'(k) + i - 2;
            if (kn < 0) kn = 0;
            else if (kn > int'(n) - 1) kn = int'(n) - 1;
            poly = ROW_COEF[4*i] * h3 + ROW_COEF[4*i+1] * h2 * 65536
                 + ROW_COEF[4*i+2] * h * (64'sd1 <<< 32) + ROW_COEF[4*i+3] * (64'sd1 <<< 48);
            // half of the polynomial, rounded half up to q16
            w = (poly + (64'sd1 <<< 32)) >>> 33;
            sum += w * longint'(model_ky[kn]);
        end
        res = (sum + 32768) >>> 16;
        if (res > 131071) res = 131071;
        if (res < -131072) res = -131072;
        r.curve_value = res[17:0];
        return r;
    endfunction

    // driver: offers pending items, predicts each accepted one
    always @(posedge i_clk) begin
        curve_item_t it;
        curve_result_t r;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                if (in_if.action == ACT_WRITE) begin
                    model_kx[in_if.key_index] = in_if.key_x;
                    model_ky[in_if.key_index] = in_if.key_y;
                    r.curve_value = '0;
                    r.status = ST_OK;
                end else begin
                    r = predict_curve(in_if.position);
                    evals_sent++;
                end
                awaited_results = {awaited_results, r};
                items_sent++;
            end
            if (!in_if.valid || in_if.ready) begin
                if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    it = pending_items.pop_front();
                    in_if.action    <= it.action;
                    in_if.key_index <= it.key_index;
                    in_if.key_x     <= it.key_x;
                    in_if.key_y     <= it.key_y;
                    in_if.position  <= it.position;
                    in_if.valid     <= 1'b1;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, counted down on its own
    always @(posedge i_clk) begin
        if (hold_request != hold_seen) begin
            hold_seen <= hold_request;
            hold_left <= LONG_HOLD;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // monitor: checks each result against the oldest expectation
    always @(posedge i_clk) begin
        curve_result_t exp_r;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (awaited_results.size() == 0) begin
                    $error("result with nothing expected: curve_value %0d status %0d",
                           out_if.curve_value, out_if.status);
                    fail_count++;
                end else begin
                    exp_r = awaited_results.pop_front();
                    if (out_if.curve_value !== exp_r.curve_value) begin
                        $error("curve_value expected %0d actual %0d",
                               exp_r.curve_value, out_if.curve_value);
                        fail_count++;
                    end
                    if (out_if.status !== exp_r.status) begin
                        $error("status expected %0d actual %0d", exp_r.status, out_if.status);
                        fail_count++;
                    end
                    results_checked++;
                end
            end
            out_if.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("catmull_rom_curve_eval_unit_test NOT OK");
            $finish;
        end
    end

    task automatic queue_write(int idx, int x, int y);
        curve_item_t it;
        it.action = ACT_WRITE;
        it.key_index = idx[3:0];
        it.key_x = x[15:0];
        it.key_y = y[15:0];
        it.position = 16'($urandom_range(65535));
        pending_items = {pending_items, it};
    endtask

    task automatic queue_eval(int pos);
        curve_item_t it;
        it.action = ACT_EVAL;
        it.key_index = 4'($urandom_range(15));
        it.key_x = 16'($urandom_range(65535));
        it.key_y = 16'($urandom_range(65535));
        it.position = pos[15:0];
        pending_items = {pending_items, it};
    endtask

    // wait until every queued item is accepted and every result has come
    task automatic wait_drained();
        while (pending_items.size() > 0 || in_if.valid || awaited_results.size() > 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_key_count(int unsigned v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v[KC_W-1:0];
        model_key_count = v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_idling(int mode);
        case (mode % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
            default: begin send_idle_pct = 8; recv_stall_pct = 8; end
        endcase
    endtask

    // one phase: a fresh full table, then evaluations around it
    task automatic run_phase(int unsigned kc, int mode, bit sorted, int n_evals);
        int xs [16];
        int tmp;
        int j;
        int n;
        int sel;
        set_key_count(kc);
        set_idling(mode);
        for (int i = 0; i < 16; i++) xs[i] = $urandom_range(65535);
        if (sorted) begin
            for (int i = 1; i < 16; i++) begin
                tmp = xs[i];
                j = i - 1;
                while (j >= 0 && xs[j] > tmp) begin
                    xs[j+1] = xs[j];
                    j--;
                end
                xs[j+1] = tmp;
            end
            // sometimes pin the ends or repeat a key
            if ($urandom_range(3) == 0) xs[0] = 0;
            if ($urandom_range(3) == 0) xs[15] = 65535;
            if ($urandom_range(3) == 0) xs[8] = xs[7];
        end
        for (int i = 0; i < 16; i++) queue_write(i, xs[i], $urandom_range(65535));
        n = (kc > 16) ? 16 : kc;
        if (n < 1) n = 1;
        for (int e = 0; e < n_evals; e++) begin
            sel = $urandom_range(9);
            if (sel < 5) queue_eval($urandom_range(65535));
            else if (sel < 8) queue_eval(xs[$urandom_range(n - 1)]);
            else begin
                tmp = xs[$urandom_range(n - 1)] + $urandom_range(8) - 4;
                if (tmp < 0) tmp = 0;
                if (tmp > 65535) tmp = 65535;
                queue_eval(tmp);
            end
        end
        wait_drained();
    endtask

    // stimulus
    initial begin
        int unsigned kc_list [10];
        kc_list = '{2, 16, 31, 3, 7, 1, 16, 0, 5, 16};
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        in_if.valid = 1'b0;
        in_if.action = ACT_WRITE;
        in_if.key_index = '0;
        in_if.key_x = '0;
        in_if.key_y = '0;
        in_if.position = '0;
        out_if.ready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        fail_count = 0;
        items_sent = 0;
        results_checked = 0;
        evals_sent = 0;
        cycle_count = 0;
        hold_request = 0;
        hold_seen = 0;
        hold_left = 0;
        model_key_count = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: no keys, extreme keys, both ends and interior
        queue_eval(16'h1234);
        queue_write(0, 0, -32768);
        queue_write(1, 1000, 32767);
        queue_write(2, 40000, -32768);
        queue_write(3, 65535, 32767);
        queue_write(4, 65535, 0);
        wait_drained();
        set_key_count(1);
        queue_eval(500);
        wait_drained();
        set_key_count(4);
        queue_eval(0);
        queue_eval(500);
        queue_eval(1000);
        queue_eval(1001);
        queue_eval(39999);
        queue_eval(20000);
        queue_eval(65535);
        wait_drained();
        queue_write(0, 300, 12345);
        queue_eval(0);
        queue_eval(300);
        wait_drained();

        // long receiver hold-off while the sender keeps offering
        hold_request = 1;
        run_phase(16, 0, 1, 30);

        for (int p = 0; p < 10; p++)
            run_phase(kc_list[p], p, (p % 5) != 4, 20);
        run_phase(8, 2, 0, 30);
        run_phase(16, 1, 1, 30);

        wait_drained();
        repeat (20) @(posedge i_clk);
        $display("covered %0d items (%0d evaluations), %0d results checked,", items_sent,
                 evals_sent, results_checked);
        $display("key_count from 0 to 31, sorted and unsorted tables, four idling patterns");
        if (fail_count == 0 && awaited_results.size() == 0) begin
            $display("catmull_rom_curve_eval_unit_test OK");
        end else begin
            $display("catmull_rom_curve_eval_unit_test NOT OK");
        end
        $finish;
    end

endmodule

// File: sim.f
hdl/cre_pkg.sv
hdl/cre_in_if.sv
hdl/cre_out_if.sv
hdl/cre_ram.sv
hdl/cre_dp.sv
hdl/cre_ctrl.sv
hdl/catmull_rom_curve_eval_unit.sv
sim/catmull_rom_curve_eval_unit_test.sv
